// ===== design/htd_pkg.sv =====
package htd_pkg;

    localparam int K_W      = 24;
    localparam int AVG_W    = 16;
    localparam int RPM_W    = 16;
    localparam int POLE_W   = 4;
    localparam int IDX_W    = 3;
    localparam int DIGITS   = 5;
    localparam int BCD_W    = 4 * DIGITS;
    localparam int CFG_A_W  = 2;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_HALL   = 2'd1;
    localparam logic [1:0] CMD_REPORT = 2'd2;

    localparam logic [CFG_A_W-1:0] REG_INDEX_POS  = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_POLE_PAIRS = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_SPEED_K    = 2'd2;

    localparam logic [IDX_W-1:0]  RST_INDEX_POS  = 3'd1;
    localparam logic [POLE_W-1:0] RST_POLE_PAIRS = 4'd2;
    localparam logic [K_W-1:0]    RST_SPEED_K    = 24'd2343750;
    localparam logic [RPM_W-1:0]  RPM_MAX        = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_BCD_GO,
        ST_BCD,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic [1:0] cmd;
        logic [2:0] hall_code;
    } t_in;

    typedef struct packed {
        logic [15:0] rpm;
        logic [3:0]  digit_ten_thousands;
        logic [3:0]  digit_thousands;
        logic [3:0]  digit_hundreds;
        logic [3:0]  digit_tens;
        logic [3:0]  digit_ones;
        logic        no_measurement;
        logic        saturated;
    } t_out;

endpackage

// ===== design/hall_tachometer_decimal_unit.sv =====
// Hall sensor tachometer with decimal readout. Tick and hall requests are taken
// in the idle state and leave the block ready for further requests. A report
// request runs a bit-serial 24/16 divider (skipped when no period has been
// measured yet) and then a shift-and-add-3 binary to decimal converter, and no
// request is accepted until the result is loaded into the result register. The
// result sits in an output register; if the previous result has not been taken
// when the next one is ready, the block waits.
module hall_tachometer_decimal_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  htd_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output htd_pkg::t_out                 o_out_data,
    input  logic                          i_cfg_we,
    input  logic [htd_pkg::CFG_A_W-1:0]   i_cfg_idx,
    input  logic [htd_pkg::K_W-1:0]       i_cfg_data
);

    htd_pkg::t_state              r_state;
    htd_pkg::t_state              n_state;

    logic [htd_pkg::IDX_W-1:0]    r_idx;
    logic [htd_pkg::POLE_W-1:0]   r_pp;
    logic [htd_pkg::K_W-1:0]      r_k;
    logic [htd_pkg::AVG_W-1:0]    r_timer;
    logic [htd_pkg::POLE_W-1:0]   r_pole;
    logic [htd_pkg::AVG_W-1:0]    r_avg;
    logic [htd_pkg::RPM_W-1:0]    r_rpm;
    logic                         r_nm;
    logic                         r_sat;
    logic                         r_out_valid;
    htd_pkg::t_out                r_out;

    logic                         in_acc;
    logic                         out_free;
    logic                         div_start;
    logic                         bcd_start;
    logic                         load;
    logic                         div_done;
    logic                         bcd_done;
    logic [htd_pkg::K_W-1:0]      quotient;
    logic [htd_pkg::BCD_W-1:0]    bcd;
    logic [htd_pkg::AVG_W:0]      avg_sum;
    logic                         q_big;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign avg_sum  = {1'b0, r_avg} + {1'b0, r_timer};
    assign q_big    = quotient[htd_pkg::K_W-1:htd_pkg::RPM_W] != '0;

    htd_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_k),
        .i_divisor  (r_avg),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    htd_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (bcd_start),
        .i_bin   (r_rpm),
        .o_done  (bcd_done),
        .o_bcd   (bcd)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            htd_pkg::ST_IDLE: begin
                if (in_acc && i_in_data.cmd == htd_pkg::CMD_REPORT) begin
                    n_state = (r_avg == '0) ? htd_pkg::ST_BCD_GO : htd_pkg::ST_DIV;
                end
            end
            htd_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = htd_pkg::ST_BCD_GO;
                end
            end
            htd_pkg::ST_BCD_GO: n_state = htd_pkg::ST_BCD;
            htd_pkg::ST_BCD: begin
                if (bcd_done) begin
                    n_state = htd_pkg::ST_LOAD;
                end
            end
            htd_pkg::ST_LOAD: begin
                if (out_free) begin
                    n_state = htd_pkg::ST_IDLE;
                end
            end
            default: n_state = htd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        div_start  = 1'b0;
        bcd_start  = 1'b0;
        load       = 1'b0;
        case (r_state)
            htd_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                div_start  = i_in_valid && i_in_data.cmd == htd_pkg::CMD_REPORT
                             && r_avg != '0;
            end
            htd_pkg::ST_BCD_GO: bcd_start = 1'b1;
            htd_pkg::ST_LOAD:   load      = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= htd_pkg::ST_IDLE;
            r_idx       <= htd_pkg::RST_INDEX_POS;
            r_pp        <= htd_pkg::RST_POLE_PAIRS;
            r_k         <= htd_pkg::RST_SPEED_K;
            r_timer     <= '0;
            r_pole      <= htd_pkg::POLE_W'(1);
            r_avg       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    htd_pkg::REG_INDEX_POS:  r_idx <= i_cfg_data[htd_pkg::IDX_W-1:0];
                    htd_pkg::REG_POLE_PAIRS: r_pp  <= i_cfg_data[htd_pkg::POLE_W-1:0];
                    htd_pkg::REG_SPEED_K:    r_k   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_acc) begin
                case (i_in_data.cmd)
                    htd_pkg::CMD_TICK: r_timer <= r_timer + 1'b1;
                    htd_pkg::CMD_HALL: begin
                        if (i_in_data.hall_code == r_idx) begin
                            if (r_pole == r_pp) begin
                                r_avg   <= avg_sum[htd_pkg::AVG_W:1];
                                r_timer <= '0;
                                r_pole  <= htd_pkg::POLE_W'(1);
                            end else begin
                                r_pole  <= r_pole + 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.cmd == htd_pkg::CMD_REPORT) begin
            r_rpm <= '0;
            r_nm  <= (r_avg == '0);
            r_sat <= 1'b0;
        end else if (r_state == htd_pkg::ST_DIV && div_done) begin
            r_rpm <= q_big ? htd_pkg::RPM_MAX : quotient[htd_pkg::RPM_W-1:0];
            r_sat <= q_big;
        end
        if (load) begin
            r_out.rpm                 <= r_rpm;
            r_out.digit_ten_thousands <= bcd[19:16];
            r_out.digit_thousands     <= bcd[15:12];
            r_out.digit_hundreds      <= bcd[11:8];
            r_out.digit_tens          <= bcd[7:4];
            r_out.digit_ones          <= bcd[3:0];
            r_out.no_measurement      <= r_nm;
            r_out.saturated           <= r_sat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == htd_pkg::ST_DIV)
        else $error("divider finished outside the divide phase");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.no_measurement && o_out_data.saturated))
        else $error("no-measurement and saturated both set");

    a_nm_zero_rpm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.no_measurement) |-> o_out_data.rpm == '0)
        else $error("rpm nonzero without a measurement");

    a_sat_max_rpm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.saturated) |-> o_out_data.rpm == htd_pkg::RPM_MAX)
        else $error("saturated result not clamped");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before it was taken");
`endif

endmodule

// ===== design/htd_divider.sv =====
module htd_divider (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [htd_pkg::K_W-1:0]    i_dividend,
    input  logic [htd_pkg::AVG_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [htd_pkg::K_W-1:0]    o_quotient
);

    localparam int CNT_W = $clog2(htd_pkg::K_W);

    logic                       r_busy;
    logic                       r_done;
    logic [CNT_W-1:0]           r_cnt;
    logic [htd_pkg::K_W-1:0]    r_quo;
    logic [htd_pkg::AVG_W-1:0]  r_rem;
    logic [htd_pkg::AVG_W-1:0]  r_div;

    logic [htd_pkg::AVG_W:0]    rem_sh;
    logic [htd_pkg::AVG_W:0]    rem_sub;
    logic                       ge;

    // one quotient bit per cycle, dividend shifts out of the quotient register
    always_comb begin
        rem_sh  = {r_rem, r_quo[htd_pkg::K_W-1]};
        ge      = rem_sh >= {1'b0, r_div};
        rem_sub = rem_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(htd_pkg::K_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[htd_pkg::K_W-2:0], ge};
            r_rem <= ge ? rem_sub[htd_pkg::AVG_W-1:0] : rem_sh[htd_pkg::AVG_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== design/htd_bcd.sv =====
module htd_bcd (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [htd_pkg::RPM_W-1:0]  i_bin,
    output logic                       o_done,
    output logic [htd_pkg::BCD_W-1:0]  o_bcd
);

    localparam int CNT_W = $clog2(htd_pkg::RPM_W);

    logic                       r_busy;
    logic                       r_done;
    logic [CNT_W-1:0]           r_cnt;
    logic [htd_pkg::RPM_W-1:0]  r_bin;
    logic [htd_pkg::BCD_W-1:0]  r_bcd;
    logic [htd_pkg::BCD_W-1:0]  adj;

    // add-3 correction on each digit before the shift
    always_comb begin
        for (int d = 0; d < htd_pkg::DIGITS; d++) begin
            adj[4*d +: 4] = (r_bcd[4*d +: 4] >= 4'd5) ? r_bcd[4*d +: 4] + 4'd3
                                                      : r_bcd[4*d +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(htd_pkg::RPM_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_bin;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bcd <= {adj[htd_pkg::BCD_W-2:0], r_bin[htd_pkg::RPM_W-1]};
            r_bin <= {r_bin[htd_pkg::RPM_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule
